// ===== hdl/gpt_pkg.sv =====
// ----------------------------------------------------------------------------
// GPT parser package
// Shared types, constants and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
`default_nettype none
package gpt_pkg;
   localparam int unsigned SectorBytesDefault = 512;
   localparam int unsigned EntryCapDefault    = 128;
   localparam logic [7:0]  MaxPartReset       = 8'd16;

   localparam logic [1:0] KIND_HDR_OK  = 2'd0;
   localparam logic [1:0] KIND_HDR_BAD = 2'd1;
   localparam logic [1:0] KIND_ENTRY   = 2'd2;

   localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
   localparam logic [63:0] EfiSig  = 64'h5452_4150_2049_4645;

   // Result transaction payload
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] part_start;
      logic [63:0] block_count;
      logic [63:0] type_guid_low;
      logic [63:0] type_guid_high;
      logic [63:0] table_lba;
      logic [7:0]  table_entry_count;
      logic [9:0]  table_entry_size;
   } result_type;

   // Entry capture handed from front to back end
   typedef struct packed {
      logic        is_header;
      logic        hdr_ok;
      logic [63:0] table_lba;
      logic [7:0]  count;
      logic [9:0]  esize;
      logic [63:0] guid_lo;
      logic [63:0] guid_hi;
      logic [63:0] first_blk;
      logic [63:0] last_blk;
      logic        guid_nz;
   } event_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/gpt_header_and_entry_parser.sv =====
// ----------------------------------------------------------------------------
// GPT header and entry parser
// Checks a GPT header sector and reports partition entries from the array.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; a byte enters every cycle while the output
//   side keeps up. Set by the byte-wide CRC and field capture.
// Result path: a result goes from the event register, loaded on the edge that
//   accepts the byte which completes it, through the two-entry queue to the
//   output register.
// Reset: synchronous; parser waits for a header, max_partitions returns to 16.
`default_nettype none
module gpt_header_and_entry_parser #(
   parameter int unsigned SECTOR_BYTES = gpt_pkg::SectorBytesDefault,
   parameter int unsigned ENTRY_CAP    = gpt_pkg::EntryCapDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // data_byte
   input  wire logic         req_tuser,   // first
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [343:0]      rsp_tdata,   // part_start, block_count, type_guid_low,
                                          // type_guid_high, table_lba,
                                          // table_entry_count, table_entry_size, pad
   output logic [1:0]        rsp_tuser,   // kind
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_data     // max_partitions
);
   logic [7:0]          maxp_ff;
   logic                ev_valid, ev_ready;
   gpt_pkg::event_type  ev_data;
   gpt_pkg::result_type res;

   // Take configuration at any time; it lands on the accepting edge.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         maxp_ff <= gpt_pkg::MaxPartReset;
      end else if (csr_valid) begin
         maxp_ff <= csr_data;
      end
   end

   gpt_front #(.SECTOR_BYTES(SECTOR_BYTES), .ENTRY_CAP(ENTRY_CAP)) u_front (
      .clock, .reset,
      .byte_valid(req_tvalid), .byte_ready(req_tready),
      .data_byte(req_tdata), .first(req_tuser),
      .max_partitions(maxp_ff),
      .ev_valid, .ev_ready, .ev_data
   );

   gpt_back u_back (
      .clock, .reset,
      .ev_valid, .ev_ready, .ev_data,
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res_data(res)
   );

   // Pack fields lowest first, pad to whole bytes.
   assign rsp_tuser = res.kind;
   assign rsp_tdata = {6'd0, res.table_entry_size, res.table_entry_count, res.table_lba,
                       res.type_guid_high, res.type_guid_low, res.block_count,
                       res.part_start};
endmodule
`default_nettype wire

// ===== hdl/gpt_front.sv =====
// ----------------------------------------------------------------------------
// GPT parser front end
// Accepts bytes, tracks header and entry positions, emits finished events.
// ----------------------------------------------------------------------------
`default_nettype none
module gpt_front #(
   parameter int unsigned SECTOR_BYTES = gpt_pkg::SectorBytesDefault,
   parameter int unsigned ENTRY_CAP    = gpt_pkg::EntryCapDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_valid,
   output logic                    byte_ready,
   input  wire logic [7:0]         data_byte,
   input  wire logic               first,
   input  wire logic [7:0]         max_partitions,
   output logic                    ev_valid,
   input  wire logic               ev_ready,
   output gpt_pkg::event_type      ev_data
);
   localparam int PW = $clog2(SECTOR_BYTES + 1);

   typedef enum logic [3:0] {
      PH_WAIT    = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_ENTRIES = 4'b0100,
      PH_IDLE    = 4'b1000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [31:0]        crc_ff, crc_in;
   logic [31:0]        scrc_ff, scrc_in;
   logic               sig_ff, sig_in;
   logic [31:0]        hsize_ff, hsize_in;
   logic [31:0]        rcount_ff, rcount_in;
   logic [63:0]        tlba_ff, tlba_in;
   logic [7:0]         left_ff, left_in;
   logic [31:0]        esize_ff, esize_in;
   logic [PW-1:0]      eoff_ff, eoff_in;
   logic [PW-1:0]      eidx_ff, eidx_in;
   logic [7:0]         found_ff, found_in;
   logic [63:0]        glo_ff, glo_in, ghi_ff, ghi_in, fb_ff, fb_in, lb_ff, lb_in;
   logic               gnz_ff, gnz_in;
   logic               evv_ff, evv_in;
   gpt_pkg::event_type ev_ff, ev_in;

   logic              acc;
   logic [7:0]        b;
   logic [PW-1:0]     p, i, eo, pos_next;
   logic [31:0]       hs, es, cnt_cap, crc_data;
   logic [32:0]       span;
   logic              ok, fire, fits;
   logic [63:0]       g0, g1, f, l;
   logic              nz;
   logic [7:0]        left, found;

   function automatic logic [7:0] EfiSigByte(input logic [2:0] k);
      return gpt_pkg::EfiSig[8*k +: 8];
   endfunction

   assign byte_ready = !evv_ff || ev_ready;
   assign acc        = byte_valid && byte_ready;
   assign ev_valid   = evv_ff;
   assign ev_data    = ev_ff;
   assign b          = data_byte;

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; crc_in = crc_ff; scrc_in = scrc_ff;
      sig_in = sig_ff; hsize_in = hsize_ff; rcount_in = rcount_ff; tlba_in = tlba_ff;
      left_in = left_ff; esize_in = esize_ff; eoff_in = eoff_ff; eidx_in = eidx_ff;
      found_in = found_ff; glo_in = glo_ff; ghi_in = ghi_ff; fb_in = fb_ff; lb_in = lb_ff;
      gnz_in = gnz_ff;
      evv_in = evv_ff && !ev_ready;
      ev_in = ev_ff;
      ok = 1'b0; fire = 1'b0; fits = 1'b0; span = '0; cnt_cap = '0; crc_data = '0;
      p = '0; i = '0; eo = '0; pos_next = '0; hs = '0; es = '0;
      g0 = '0; g1 = '0; f = '0; l = '0; nz = 1'b0; left = '0; found = '0;
      if (acc) begin
         if (first) begin
            phase_in = PH_HEADER; pos_in = '0; crc_in = '1; scrc_in = '0; sig_in = 1'b1;
            hsize_in = '0; rcount_in = '0; tlba_in = '0; left_in = '0; esize_in = '0;
            eoff_in = '0; eidx_in = '0; found_in = '0;
            glo_in = '0; ghi_in = '0; fb_in = '0; lb_in = '0; gnz_in = 1'b0;
         end
         p = pos_in; hs = hsize_in; es = esize_in; left = left_in; found = found_in;
         case (phase_in)
            PH_HEADER: begin
               crc_data = crc_in;
               if (p < PW'(8) && b != EfiSigByte(p[2:0])) sig_in = 1'b0;
               if (p >= PW'(12) && p < PW'(16)) hsize_in = hs | (32'(b) << (8 * p[1:0]));
               if (p >= PW'(16) && p < PW'(20))
                  scrc_in = scrc_in | (32'(b) << (8 * p[1:0]));
               if (p >= PW'(72) && p < PW'(80))
                  tlba_in = tlba_in | (64'(b) << (8 * p[2:0]));
               if (p >= PW'(80) && p < PW'(84))
                  rcount_in = rcount_in | (32'(b) << (8 * p[1:0]));
               if (p >= PW'(84) && p < PW'(88))
                  esize_in = es | (32'(b) << (8 * p[1:0]));
               if (p < PW'(16) || 32'(p) < hs)
                  crc_in = gpt_pkg::crc_byte(crc_data,
                     (p >= PW'(16) && p < PW'(20)) ? 8'd0 : b);
               pos_next = p + PW'(1);
               pos_in = pos_next;
               if (32'(pos_next) >= SECTOR_BYTES) begin
                  pos_in = '0;
                  ok = sig_in && hsize_in >= 32'd92 && hsize_in <= SECTOR_BYTES &&
                       (crc_in ^ 32'hFFFF_FFFF) == scrc_in &&
                       esize_in >= 32'd128 && esize_in <= SECTOR_BYTES;
                  cnt_cap = (rcount_in > ENTRY_CAP) ? 32'(ENTRY_CAP) : rcount_in;
                  evv_in = 1'b1;
                  ev_in = '0;
                  ev_in.is_header = 1'b1;
                  ev_in.hdr_ok = ok;
                  if (ok) begin
                     left_in = cnt_cap[7:0];
                     ev_in.table_lba = tlba_in;
                     ev_in.count = cnt_cap[7:0];
                     ev_in.esize = esize_in[9:0];
                     eidx_in = '0; found_in = '0;
                     glo_in = '0; ghi_in = '0; fb_in = '0; lb_in = '0; gnz_in = 1'b0;
                     phase_in = (cnt_cap == 32'd0 || max_partitions == 8'd0) ?
                                PH_IDLE : PH_ENTRIES;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_ENTRIES: begin
               i = eidx_in;
               eo = (i == '0) ? p : eoff_in;
               eoff_in = eo;
               g0 = (i == '0) ? 64'd0 : glo_in;  g1 = (i == '0) ? 64'd0 : ghi_in;
               f  = (i == '0) ? 64'd0 : fb_in;   l  = (i == '0) ? 64'd0 : lb_in;
               nz = (i == '0) ? 1'b0 : gnz_in;
               span = 33'(eo) + 33'(es);
               fits = span <= 33'(SECTOR_BYTES);
               if (fits) begin
                  if (i < PW'(8)) g0 = g0 | (64'(b) << (8 * i[2:0]));
                  else if (i < PW'(16)) g1 = g1 | (64'(b) << (8 * i[2:0]));
                  else if (i >= PW'(32) && i < PW'(40)) f = f | (64'(b) << (8 * i[2:0]));
                  else if (i >= PW'(40) && i < PW'(48)) l = l | (64'(b) << (8 * i[2:0]));
                  if (i < PW'(16) && b != 8'd0) nz = 1'b1;
                  if (32'(i) + 32'd1 >= es) begin
                     eidx_in = '0;
                     if (left != 8'd0 && found < max_partitions) begin
                        left = left - 8'd1;
                        if (nz && l >= f) begin
                           fire = 1'b1;
                           found = found + 8'd1;
                        end
                     end
                     if (left == 8'd0 || found >= max_partitions) phase_in = PH_IDLE;
                  end else begin
                     eidx_in = i + PW'(1);
                  end
               end
               left_in = left; found_in = found;
               glo_in = g0; ghi_in = g1; fb_in = f; lb_in = l; gnz_in = nz;
               if (fire) begin
                  evv_in = 1'b1;
                  ev_in = '0;
                  ev_in.guid_lo = g0; ev_in.guid_hi = g1;
                  ev_in.first_blk = f; ev_in.last_blk = l; ev_in.guid_nz = nz;
               end
               pos_next = p + PW'(1);
               pos_in = pos_next;
               if (32'(pos_next) >= SECTOR_BYTES) begin
                  pos_in = '0;
                  eidx_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT; evv_ff <= 1'b0;
         pos_ff <= '0; eidx_ff <= '0; left_ff <= '0; found_ff <= '0;
      end else begin
         phase_ff <= phase_in; evv_ff <= evv_in;
         pos_ff <= pos_in; eidx_ff <= eidx_in; left_ff <= left_in; found_ff <= found_in;
      end
      crc_ff <= crc_in; scrc_ff <= scrc_in; sig_ff <= sig_in; hsize_ff <= hsize_in;
      rcount_ff <= rcount_in; tlba_ff <= tlba_in; esize_ff <= esize_in; eoff_ff <= eoff_in;
      glo_ff <= glo_in; ghi_ff <= ghi_in; fb_ff <= fb_in; lb_ff <= lb_in; gnz_ff <= gnz_in;
      ev_ff <= ev_in;
   end

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("parse phase not one-hot");
   a_ev_hold: assert property (@(posedge clock) disable iff (reset)
      (evv_ff && !ev_ready) |=> evv_ff)
      else $error("event dropped while stalled");
   a_no_acc_blocked: assert property (@(posedge clock) disable iff (reset)
      (evv_ff && !ev_ready) |-> !byte_ready)
      else $error("byte accepted with a stalled event");
endmodule
`default_nettype wire

// ===== hdl/gpt_back.sv =====
// ----------------------------------------------------------------------------
// GPT parser back end
// Two-entry queue of events, then result formatting into an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module gpt_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               ev_valid,
   output logic                    ev_ready,
   input  wire gpt_pkg::event_type ev_data,
   output logic                    res_valid,
   input  wire logic               res_ready,
   output gpt_pkg::result_type     res_data
);
   gpt_pkg::event_type  q_ff [2];
   gpt_pkg::event_type  q_in [2];
   logic [1:0]          cnt_ff, cnt_in;
   logic                ov_ff, ov_in;
   gpt_pkg::result_type out_ff, out_in;
   logic                push, pop;
   gpt_pkg::event_type  h;

   assign ev_ready  = cnt_ff != 2'd2;
   assign push      = ev_valid && ev_ready;
   assign pop       = cnt_ff != 2'd0 && (!ov_ff || res_ready);
   assign res_valid = ov_ff;
   assign res_data  = out_ff;
   assign h         = q_ff[0];

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      ov_in = ov_ff && !res_ready;
      out_in = out_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
         ov_in = 1'b1;
         out_in = '0;
         if (h.is_header) begin
            out_in.kind = h.hdr_ok ? gpt_pkg::KIND_HDR_OK : gpt_pkg::KIND_HDR_BAD;
            if (h.hdr_ok) begin
               out_in.table_lba = h.table_lba;
               out_in.table_entry_count = h.count;
               out_in.table_entry_size = h.esize;
            end
         end else begin
            out_in.kind = gpt_pkg::KIND_ENTRY;
            out_in.part_start = h.first_blk;
            out_in.block_count = h.last_blk - h.first_blk + 64'd1;
            out_in.type_guid_low = h.guid_lo;
            out_in.type_guid_high = h.guid_hi;
         end
      end
      if (push) begin
         q_in[cnt_in[0]] = ev_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; ov_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; ov_ff <= ov_in;
      end
      q_ff <= q_in;
      out_ff <= out_in;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue overfilled");
   a_pop_out: assert property (@(posedge clock) disable iff (reset) pop |=> ov_ff)
      else $error("popped event not shown");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !res_ready) |=> $stable(out_ff))
      else $error("result changed while stalled");
endmodule
`default_nettype wire

// ===== dv/gpt_header_and_entry_parser_tb.sv =====
// ----------------------------------------------------------------------------
// GPT header and entry parser testbench
// Streams header and entry-array sectors into the parser and checks every
// reported header verdict and partition entry against a cycle-free predictor
// that tracks the same parse state byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none
module gpt_header_and_entry_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SectorLen  = 512;
   localparam int EntryLimit = 128;
   localparam longint CycleLimit = 64'd3_000_000;

   typedef enum logic [3:0] {
      PH_WAIT    = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_ENTRIES = 4'b0100,
      PH_IDLE    = 4'b1000
   } parse_phase_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // data_byte
   logic         req_tuser;   // first
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [343:0] rsp_tdata;   // part_start, block_count, type_guid_low,
                              // type_guid_high, table_lba,
                              // table_entry_count, table_entry_size, pad
   logic [1:0]   rsp_tuser;   // kind
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_data;    // max_partitions

   gpt_header_and_entry_parser dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Predictor state
   logic [7:0]      p_max_parts;
   parse_phase_type p_phase;
   int unsigned     p_pos;
   logic [31:0]     p_crc;
   logic [31:0]     p_stored_crc;
   logic            p_sig_ok;
   logic [31:0]     p_hdr_size;
   logic [31:0]     p_raw_count;
   logic [63:0]     p_table_lba;
   int unsigned     p_count_left;
   logic [31:0]     p_entry_size;
   int unsigned     p_entry_offset;
   int unsigned     p_entry_idx;
   int unsigned     p_found;
   logic [63:0]     p_guid_lo, p_guid_hi, p_first_blk, p_last_blk;
   logic            p_guid_nz;

   gpt_pkg::result_type expected_results[$];
   int              mismatch_count;
   longint          cycle_count;
   int              rsp_wait;

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
      return r;
   endfunction

   task automatic clear_entry_capture();
      p_guid_lo = '0; p_guid_hi = '0; p_first_blk = '0; p_last_blk = '0;
      p_guid_nz = 1'b0;
   endtask

   task automatic restart_header();
      p_phase = PH_HEADER; p_pos = 0; p_crc = '1; p_stored_crc = '0; p_sig_ok = 1'b1;
      p_hdr_size = '0; p_raw_count = '0; p_table_lba = '0; p_count_left = 0;
      p_entry_size = '0; p_entry_offset = 0; p_entry_idx = 0; p_found = 0;
      clear_entry_capture();
   endtask

   // Advance the parse by one byte and queue any result it produces
   task automatic predict_byte(input logic [7:0] b, input logic first_flag);
      gpt_pkg::result_type r;
      logic [7:0] crc_in;
      logic [63:0] sig;
      int unsigned p, i;
      bit ok;
      r = '0;
      sig = 64'h5452_4150_2049_4645;
      if (first_flag) restart_header();
      if (p_phase == PH_HEADER) begin
         p = p_pos;
         crc_in = b;
         if (p < 8 && b != sig[p*8 +: 8]) p_sig_ok = 1'b0;
         if (p >= 12 && p < 16) p_hdr_size[(p-12)*8 +: 8] = b;
         if (p >= 16 && p < 20) begin
            p_stored_crc[(p-16)*8 +: 8] = b;
            crc_in = 8'd0;
         end
         if (p >= 'h48 && p < 'h50) p_table_lba[(p-'h48)*8 +: 8] = b;
         if (p >= 'h50 && p < 'h54) p_raw_count[(p-'h50)*8 +: 8] = b;
         if (p >= 'h54 && p < 'h58) p_entry_size[(p-'h54)*8 +: 8] = b;
         if (p < 16 || p < p_hdr_size) p_crc = crc_step(p_crc, crc_in);
         p_pos = p + 1;
         if (p_pos >= SectorLen) begin
            p_pos = 0;
            ok = p_sig_ok && p_hdr_size >= 92 && p_hdr_size <= SectorLen
                 && ~p_crc == p_stored_crc
                 && p_entry_size >= 128 && p_entry_size <= SectorLen;
            if (!ok) begin
               r.kind = gpt_pkg::KIND_HDR_BAD;
               p_phase = PH_IDLE;
            end else begin
               p_count_left = (p_raw_count > EntryLimit) ? EntryLimit : p_raw_count;
               r.kind = gpt_pkg::KIND_HDR_OK;
               r.table_lba = p_table_lba;
               r.table_entry_count = p_count_left[7:0];
               r.table_entry_size = p_entry_size[9:0];
               p_entry_idx = 0;
               p_found = 0;
               clear_entry_capture();
               p_phase = (p_count_left == 0 || p_found >= p_max_parts) ? PH_IDLE : PH_ENTRIES;
            end
            expected_results.push_back(r);
         end
      end else if (p_phase == PH_ENTRIES) begin
         i = p_entry_idx;
         if (i == 0) begin
            p_entry_offset = p_pos;
            clear_entry_capture();
         end
         if (p_entry_offset + p_entry_size <= SectorLen) begin
            if (i < 8) p_guid_lo[i*8 +: 8] = b;
            else if (i < 16) p_guid_hi[(i-8)*8 +: 8] = b;
            else if (i >= 'h20 && i < 'h28) p_first_blk[(i-'h20)*8 +: 8] = b;
            else if (i >= 'h28 && i < 'h30) p_last_blk[(i-'h28)*8 +: 8] = b;
            if (i < 16 && b != 0) p_guid_nz = 1'b1;
            if (i + 1 >= p_entry_size) begin
               p_entry_idx = 0;
               if (p_count_left > 0 && p_found < p_max_parts) begin
                  p_count_left--;
                  if (p_guid_nz && p_last_blk >= p_first_blk) begin
                     r.kind = gpt_pkg::KIND_ENTRY;
                     r.part_start = p_first_blk;
                     r.block_count = p_last_blk - p_first_blk + 64'd1;
                     r.type_guid_low = p_guid_lo;
                     r.type_guid_high = p_guid_hi;
                     p_found++;
                     expected_results.push_back(r);
                  end
               end
               if (p_count_left == 0 || p_found >= p_max_parts) p_phase = PH_IDLE;
            end else begin
               p_entry_idx = i + 1;
            end
         end
         p_pos++;
         if (p_pos >= SectorLen) begin
            p_pos = 0;
            p_entry_idx = 0;
         end
      end
   endtask

   // Send one byte transaction with a random gap ahead of it; hold valid
   // across back-to-back transactions
   task automatic send_byte(input logic [7:0] b, input logic first_flag);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, first_flag);
   endtask

   task automatic send_sector(input logic [7:0] sector[SectorLen], input bit mark_first);
      for (int k = 0; k < SectorLen; k++) send_byte(sector[k], mark_first && k == 0);
   endtask

   task automatic send_send(input logic [7:0] s[SectorLen]);
      send_sector(s, 1'b1);
   endtask

   // Build a header sector; corrupt selects one fault to inject (0 none)
   task automatic build_header(output logic [7:0] s[SectorLen], input logic [31:0] hsize,
                               input logic [63:0] lba, input logic [31:0] count,
                               input logic [31:0] esize, input int corrupt);
      logic [31:0] c;
      logic [63:0] sig;
      sig = 64'h5452_4150_2049_4645;
      for (int k = 0; k < SectorLen; k++) s[k] = 8'($urandom_range(0, 255));
      for (int k = 0; k < 8; k++) s[k] = sig[k*8 +: 8];
      for (int k = 0; k < 4; k++) begin
         s[12+k] = hsize[k*8 +: 8];
         s[16+k] = 8'd0;
         s['h50+k] = count[k*8 +: 8];
         s['h54+k] = esize[k*8 +: 8];
      end
      for (int k = 0; k < 8; k++) s['h48+k] = lba[k*8 +: 8];
      c = '1;
      for (int k = 0; k < SectorLen; k++)
         if (k < 16 || k < hsize) c = crc_step(c, s[k]);
      c = ~c;
      for (int k = 0; k < 4; k++) s[16+k] = c[k*8 +: 8];
      if (corrupt == 1) s[$urandom_range(0, 7)] ^= 8'h20;
      if (corrupt == 2) s[16] ^= 8'h01;
   endtask

   // Entry sector: each entry randomly used, empty or reversed
   task automatic build_entries(output logic [7:0] s[SectorLen], input int esize);
      logic [63:0] fb, lb;
      int mode;
      for (int k = 0; k < SectorLen; k++) s[k] = 8'($urandom_range(0, 255));
      for (int e = 0; e + esize <= SectorLen; e += esize) begin
         mode = $urandom_range(0, 9);
         fb = {$urandom, $urandom};
         if ($urandom_range(0, 1)) fb = fb >> $urandom_range(0, 63);
         lb = fb + ({$urandom, $urandom} >> $urandom_range(0, 63));
         if (mode == 0) for (int k = 0; k < 16; k++) s[e+k] = 8'd0;
         if (mode == 1) lb = fb - 64'd1 - $urandom_range(0, 5);
         if (mode == 2) lb = fb;
         if (mode == 3) begin
            fb = 64'd0;
            lb = '1;
         end
         if (fb == 0 && mode == 1) fb = 64'd3;
         for (int k = 0; k < 8; k++) begin
            s[e+'h20+k] = fb[k*8 +: 8];
            s[e+'h28+k] = lb[k*8 +: 8];
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_max_parts(input logic [7:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      p_max_parts = v;
   endtask

   // One table: header then n entry sectors
   task automatic run_table(input int esize, input logic [31:0] count, input int n_sectors,
                            input int corrupt);
      logic [7:0] s[SectorLen];
      build_header(s, 92 + $urandom_range(0, 3) * $urandom_range(0, 140), {$urandom, $urandom},
                   count, esize, corrupt);
      send_sector(s, 1'b1);
      for (int k = 0; k < n_sectors; k++) begin
         build_entries(s, esize);
         send_sector(s, 1'b0);
      end
   endtask

   // Stray bytes before a header, fault injection, odd sizes and restarts
   task automatic test_directed();
      logic [7:0] s[SectorLen];
      for (int k = 0; k < 6; k++) send_byte(8'hFF * k[0], 1'b0);
      run_table(128, 4, 1, 0);
      run_table(128, 4, 0, 1);
      run_table(128, 4, 0, 2);
      build_header(s, 91, 64'd2, 4, 128, 0);          send_send(s);
      build_header(s, 513, 64'd2, 4, 128, 0);         send_send(s);
      build_header(s, 512, '1, 4, 127, 0);            send_send(s);
      build_header(s, 512, '1, 4, 513, 0);            send_send(s);
      build_header(s, 92, '1, 32'hFFFF_FFFF, 512, 0); send_send(s);
      build_header(s, 92, 64'd0, 0, 200, 0);          send_send(s);
      build_entries(s, 200); send_sector(s, 1'b0);
      run_table(200, 6, 2, 0);
      run_table(512, 3, 2, 0);
      // Restart midway through an entry sector
      run_table(128, 8, 0, 0);
      for (int k = 0; k < 70; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      run_table(128, 8, 2, 0);
   endtask

   task automatic test_register_settings();
      write_max_parts(8'd0);   run_table(128, 8, 1, 0);
      write_max_parts(8'd1);   run_table(128, 8, 1, 0);
      write_max_parts(8'd255); run_table(128, 200, 2, 0);
      write_max_parts(8'd128); run_table(256, 20, 2, 0);
   endtask

   task automatic test_random_tables();
      int esize, pick;
      for (int t = 0; t < 12; t++) begin
         if (t % 4 == 0) write_max_parts(8'($urandom_range(1, 20)));
         pick = $urandom_range(0, 9);
         esize = (pick < 6) ? 128 : (pick < 8 ? 256 : $urandom_range(128, 512));
         run_table(esize, $urandom_range(0, 40), $urandom_range(0, 2),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
         if (pick == 9)
            for (int k = 0; k < 20; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin
      gpt_pkg::result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         {got.table_entry_size, got.table_entry_count, got.table_lba, got.type_guid_high,
          got.type_guid_low, got.block_count, got.part_start} = rsp_tdata[337:0];
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result differs: expected %h actual %h", want, got);
            end
         end
      end
   end

   // Hold off the result side: draw a random wait for every result
   always @(posedge clock) begin
      int w;
      cycle_count <= cycle_count + 1;
      w = $urandom_range(0, 5);
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= w;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait   <= w;
         rsp_tready <= (w == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait   <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("gpt_header_and_entry_parser: mismatch");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0;
      csr_valid = 1'b0; csr_data = '0; rsp_tready = 1'b0;
      mismatch_count = 0; cycle_count = 0; rsp_wait = 0;
      p_max_parts = 8'd16;
      restart_header();
      p_phase = PH_WAIT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_settings();
      test_random_tables();
      wait_drained();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("gpt_header_and_entry_parser: match");
      end else begin
         $display("gpt_header_and_entry_parser: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire
